[rtl/rsc_pkg.sv]
// Shared types, codes and microcode ROM for the RPN stack calculator.
package rsc_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int DW            = 32;
  localparam int DIV_STEPS     = 32;
  localparam int DIV_CW        = $clog2(DIV_STEPS + 1);
  localparam int PC_W          = 4;

  // request modes
  localparam logic [2:0] MODE_PUSH  = 3'd0;
  localparam logic [2:0] MODE_POP   = 3'd1;
  localparam logic [2:0] MODE_ADD   = 3'd2;
  localparam logic [2:0] MODE_SUB   = 3'd3;
  localparam logic [2:0] MODE_MUL   = 3'd4;
  localparam logic [2:0] MODE_DIV   = 3'd5;
  localparam logic [2:0] MODE_CLEAR = 3'd6;

  // result status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW    = 3'd1;
  localparam logic [2:0] ST_INSUFFICIENT = 3'd2;
  localparam logic [2:0] ST_DIVZERO      = 3'd3;
  localparam logic [2:0] ST_FULL         = 3'd4;

  typedef enum logic [3:0] {
    U_NOP       = 4'd0,
    U_PUSH      = 4'd1,
    U_POP_CHK   = 4'd2,
    U_POP_DATA  = 4'd3,
    U_OP_CHK    = 4'd4,
    U_OP_RD2    = 4'd5,
    U_OP_RDL    = 4'd6,
    U_ALU       = 4'd7,
    U_DIV_START = 4'd8,
    U_DIV_TAKE  = 4'd9,
    U_WB        = 4'd10,
    U_FIN       = 4'd11,
    U_CLEAR     = 4'd12
  } uop_t;

  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_EMPTY    = 3'd1,
    C_FEW      = 3'd2,
    C_IS_DIV   = 3'd3,
    C_RZERO    = 3'd4,
    C_DIV_BUSY = 3'd5,
    C_OUT_FREE = 3'd6
  } cond_t;

  typedef struct packed {
    uop_t            uop;
    cond_t           cond;
    logic [PC_W-1:0] jt;
    logic [PC_W-1:0] jf;
  } ucode_t;

  typedef struct packed {
    logic empty;
    logic few;
    logic is_div;
    logic right_zero;
    logic div_busy;
    logic out_free;
  } flags_t;

  // microcode addresses
  localparam logic [PC_W-1:0] A_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] A_PUSH      = 4'd1;
  localparam logic [PC_W-1:0] A_POP_CHK   = 4'd2;
  localparam logic [PC_W-1:0] A_POP_DATA  = 4'd3;
  localparam logic [PC_W-1:0] A_OP_CHK    = 4'd4;
  localparam logic [PC_W-1:0] A_OP_RD2    = 4'd5;
  localparam logic [PC_W-1:0] A_OP_RDL    = 4'd6;
  localparam logic [PC_W-1:0] A_ALU       = 4'd7;
  localparam logic [PC_W-1:0] A_DIV_CHK   = 4'd8;
  localparam logic [PC_W-1:0] A_DIV_WAIT  = 4'd9;
  localparam logic [PC_W-1:0] A_DIV_TAKE  = 4'd10;
  localparam logic [PC_W-1:0] A_WB        = 4'd11;
  localparam logic [PC_W-1:0] A_FIN       = 4'd12;
  localparam logic [PC_W-1:0] A_CLEAR     = 4'd13;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{U_NOP, C_ALWAYS, A_IDLE, A_IDLE};
    unique case (pc)
      A_IDLE:     w = '{U_NOP,       C_ALWAYS,   A_IDLE,     A_IDLE};
      A_PUSH:     w = '{U_PUSH,      C_ALWAYS,   A_FIN,      A_FIN};
      A_POP_CHK:  w = '{U_POP_CHK,   C_EMPTY,    A_FIN,      A_POP_DATA};
      A_POP_DATA: w = '{U_POP_DATA,  C_ALWAYS,   A_FIN,      A_FIN};
      A_OP_CHK:   w = '{U_OP_CHK,    C_FEW,      A_FIN,      A_OP_RD2};
      A_OP_RD2:   w = '{U_OP_RD2,    C_ALWAYS,   A_OP_RDL,   A_OP_RDL};
      A_OP_RDL:   w = '{U_OP_RDL,    C_IS_DIV,   A_DIV_CHK,  A_ALU};
      A_ALU:      w = '{U_ALU,       C_ALWAYS,   A_WB,       A_WB};
      A_DIV_CHK:  w = '{U_DIV_START, C_RZERO,    A_FIN,      A_DIV_WAIT};
      A_DIV_WAIT: w = '{U_NOP,       C_DIV_BUSY, A_DIV_WAIT, A_DIV_TAKE};
      A_DIV_TAKE: w = '{U_DIV_TAKE,  C_ALWAYS,   A_WB,       A_WB};
      A_WB:       w = '{U_WB,        C_ALWAYS,   A_FIN,      A_FIN};
      A_FIN:      w = '{U_FIN,       C_OUT_FREE, A_IDLE,     A_FIN};
      A_CLEAR:    w = '{U_CLEAR,     C_ALWAYS,   A_FIN,      A_FIN};
      default:    w = '{U_NOP,       C_ALWAYS,   A_IDLE,     A_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] mode_entry(input logic [2:0] mode);
    logic [PC_W-1:0] a;
    a = A_FIN;
    unique case (mode)
      MODE_PUSH:  a = A_PUSH;
      MODE_POP:   a = A_POP_CHK;
      MODE_ADD:   a = A_OP_CHK;
      MODE_SUB:   a = A_OP_CHK;
      MODE_MUL:   a = A_OP_CHK;
      MODE_DIV:   a = A_OP_CHK;
      MODE_CLEAR: a = A_CLEAR;
      default:    a = A_FIN;
    endcase
    return a;
  endfunction

endpackage

[rtl/rsc_stack_mem.sv]
// Stack storage: one write port, one read port with registered read data.
module rsc_stack_mem #(
  parameter int DEPTH = rsc_pkg::DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [rsc_pkg::DW-1:0] wr_data,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [rsc_pkg::DW-1:0] rd_data
);

  logic [rsc_pkg::DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/rsc_div.sv]
// Iterative signed divider, truncating quotient, one quotient bit per cycle.
module rsc_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [rsc_pkg::DW-1:0] dividend,
  input  logic [rsc_pkg::DW-1:0] divisor,
  output logic                   busy,
  output logic [rsc_pkg::DW-1:0] quot
);

  localparam int DW = rsc_pkg::DW;

  logic [rsc_pkg::DIV_CW-1:0] step;
  logic [DW-1:0]              rem;
  logic [DW-1:0]              q;
  logic [DW-1:0]              dv;
  logic                       neg;
  logic [DW:0]                shifted;
  logic [DW:0]                diff;

  assign shifted = {rem, q[DW-1]};
  assign diff    = shifted - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && step == rsc_pkg::DIV_CW'(rsc_pkg::DIV_STEPS)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      q    <= dividend[DW-1] ? (DW'(0) - dividend) : dividend;
      dv   <= divisor[DW-1] ? (DW'(0) - divisor) : divisor;
      neg  <= dividend[DW-1] ^ divisor[DW-1];
      step <= '0;
    end else if (busy) begin
      if (step == rsc_pkg::DIV_CW'(rsc_pkg::DIV_STEPS)) begin
        quot <= neg ? (DW'(0) - q) : q;
      end else begin
        step <= step + 1'b1;
        if (!diff[DW]) begin
          rem <= diff[DW-1:0];
          q   <= {q[DW-2:0], 1'b1};
        end else begin
          rem <= shifted[DW-1:0];
          q   <= {q[DW-2:0], 1'b0};
        end
      end
    end
  end

endmodule

[rtl/rsc_seq.sv]
// Microcode sequencer: step counter, control ROM and conditional jumps.
module rsc_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [2:0]               mode,
  input  rsc_pkg::flags_t          flags,
  output rsc_pkg::uop_t            uop,
  output logic                     idle
);

  logic [rsc_pkg::PC_W-1:0] pc;
  logic [rsc_pkg::PC_W-1:0] pc_next;
  rsc_pkg::ucode_t          word;
  logic                     taken;

  assign word = rsc_pkg::ucode_rom(pc);
  assign uop  = word.uop;
  assign idle = (pc == rsc_pkg::A_IDLE);

  always_comb begin
    unique case (word.cond)
      rsc_pkg::C_ALWAYS:   taken = 1'b1;
      rsc_pkg::C_EMPTY:    taken = flags.empty;
      rsc_pkg::C_FEW:      taken = flags.few;
      rsc_pkg::C_IS_DIV:   taken = flags.is_div;
      rsc_pkg::C_RZERO:    taken = flags.right_zero;
      rsc_pkg::C_DIV_BUSY: taken = flags.div_busy;
      rsc_pkg::C_OUT_FREE: taken = flags.out_free;
      default:             taken = 1'b1;
    endcase
  end

  always_comb begin
    if (idle) begin
      pc_next = accept ? rsc_pkg::mode_entry(mode) : rsc_pkg::A_IDLE;
    end else begin
      pc_next = taken ? word.jt : word.jf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= rsc_pkg::A_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

[rtl/rpn_stack_calculator_top.sv]
// RPN stack calculator: top level with datapath, stack memory, divider and sequencer.
//
// Request channel (req_valid/req_stall, mode, value): one request per beat,
// push, pop, add, subtract, multiply, divide or clear. Result channel
// (rsp_valid/rsp_stall, status, data, is_empty, depth): exactly one beat per
// request, in request order.
// One request is in work at a time; req_stall is high from acceptance until
// the result has been loaded into the output register.
// Steps after acceptance: push and clear update the stack; pop checks, then
// reads its data; add, subtract, multiply check, read both operands, compute
// and write back; divide uses the one-bit-per-cycle divider with its sign
// fixup in place of the compute. An unused mode goes straight to the finish
// step. The next request is taken in the cycle after the result is loaded.
// Reset (rst, synchronous) empties the stack and drops any pending result;
// stack contents are not cleared, entries are only read after being written.
// While rsp_stall holds a result, the sequencer waits in its final step and
// no new request is taken.
module rpn_stack_calculator_top #(
  parameter int DEPTH = rsc_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [2:0]                    mode,
  input  logic signed [rsc_pkg::DW-1:0] value,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [2:0]                    status,
  output logic signed [rsc_pkg::DW-1:0] data,
  output logic                          is_empty,
  output logic [6:0]                    depth
);

  localparam int DW = rsc_pkg::DW;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic            accept;
  logic            seq_idle;
  rsc_pkg::uop_t   uop;
  rsc_pkg::flags_t flags;

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   cnt_m2;
  logic [CW+6:0]   cnt_wide;
  logic            empty;
  logic            one;
  logic            full;
  logic            out_free;

  logic [2:0]      mode_q;
  logic [DW-1:0]   value_q;
  logic [2:0]      status_q;
  logic [DW-1:0]   data_q;
  logic [DW-1:0]   left_q;
  logic [DW-1:0]   right_q;
  logic [DW-1:0]   result_q;
  logic [DW-1:0]   alu;
  logic            right_zero;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [DW-1:0]   wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [DW-1:0]   rd_data;

  logic            div_start;
  logic            div_busy;
  logic [DW-1:0]   div_quot;

  assign req_stall  = !seq_idle;
  assign accept     = req_valid && !req_stall;
  assign cnt_m1     = count - 1'b1;
  assign cnt_m2     = count - 2'd2;
  assign cnt_wide   = {7'd0, count};
  assign empty      = (count == '0);
  assign one        = (count == CW'(1));
  assign full       = (count == DEPTH_C);
  assign out_free   = !rsp_valid || !rsp_stall;
  assign right_zero = (right_q == '0);

  assign flags.empty      = empty;
  assign flags.few        = empty || one;
  assign flags.is_div     = (mode_q == rsc_pkg::MODE_DIV);
  assign flags.right_zero = right_zero;
  assign flags.div_busy   = div_busy;
  assign flags.out_free   = out_free;

  always_comb begin
    unique case (mode_q)
      rsc_pkg::MODE_ADD: alu = left_q + right_q;
      rsc_pkg::MODE_SUB: alu = left_q - right_q;
      default:           alu = left_q * right_q;
    endcase
  end

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = count[AW-1:0];
    wr_data    = value_q;
    rd_en      = 1'b0;
    rd_addr    = cnt_m1[AW-1:0];
    div_start  = 1'b0;
    count_next = count;
    unique case (uop)
      rsc_pkg::U_PUSH: begin
        if (!full) begin
          wr_en      = 1'b1;
          count_next = count + 1'b1;
        end
      end
      rsc_pkg::U_POP_CHK: begin
        if (!empty) begin
          rd_en      = 1'b1;
          count_next = cnt_m1;
        end
      end
      rsc_pkg::U_OP_CHK: begin
        if (one) begin
          count_next = '0;
        end else if (!empty) begin
          rd_en = 1'b1;
        end
      end
      rsc_pkg::U_OP_RD2: begin
        rd_en      = 1'b1;
        rd_addr    = cnt_m2[AW-1:0];
        count_next = cnt_m2;
      end
      rsc_pkg::U_DIV_START: div_start = !right_zero;
      rsc_pkg::U_WB: begin
        wr_en      = 1'b1;
        wr_data    = result_q;
        count_next = count + 1'b1;
      end
      rsc_pkg::U_CLEAR: count_next = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (uop == rsc_pkg::U_FIN && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q   <= mode;
      value_q  <= value;
      status_q <= rsc_pkg::ST_OK;
      data_q   <= '0;
    end
    unique case (uop)
      rsc_pkg::U_PUSH: begin
        if (full) status_q <= rsc_pkg::ST_FULL;
      end
      rsc_pkg::U_POP_CHK: begin
        if (empty) status_q <= rsc_pkg::ST_UNDERFLOW;
      end
      rsc_pkg::U_POP_DATA: data_q <= rd_data;
      rsc_pkg::U_OP_CHK: begin
        if (empty) begin
          status_q <= rsc_pkg::ST_UNDERFLOW;
        end else if (one) begin
          status_q <= rsc_pkg::ST_INSUFFICIENT;
        end
      end
      rsc_pkg::U_OP_RD2: right_q <= rd_data;
      rsc_pkg::U_OP_RDL: left_q <= rd_data;
      rsc_pkg::U_ALU: result_q <= alu;
      rsc_pkg::U_DIV_START: begin
        if (right_zero) status_q <= rsc_pkg::ST_DIVZERO;
      end
      rsc_pkg::U_DIV_TAKE: result_q <= div_quot;
      rsc_pkg::U_WB: data_q <= result_q;
      rsc_pkg::U_FIN: begin
        if (out_free) begin
          status   <= status_q;
          data     <= data_q;
          is_empty <= empty;
          depth    <= cnt_wide[6:0];
        end
      end
      default: ;
    endcase
  end

  rsc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .mode   (mode),
    .flags  (flags),
    .uop    (uop),
    .idle   (seq_idle)
  );

  rsc_stack_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (left_q),
    .divisor  (right_q),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("stack count above depth");

  a_div_idle : assert property (@(posedge clk) disable iff (rst)
    seq_idle |-> !div_busy)
    else $error("divider busy while sequencer idle");

  a_fail_no_data : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != rsc_pkg::ST_OK) |-> (data == '0))
    else $error("failed request carries nonzero data");

endmodule

[tb/sv/tb_rpn_stack_calculator_top.sv]
// Self-checking testbench for the RPN stack calculator: directed and random requests.
`timescale 1ns / 100ps

module tb_rpn_stack_calculator_top;

  localparam int         STACK_DEPTH  = rsc_pkg::DEPTH_DEFAULT;
  localparam logic [2:0] MODE_UNUSED  = 3'd7;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         DRAIN_CYCLES = 60;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         REPORT_MAX   = 10;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] data;
    logic        empty;
    logic [6:0]  depth;
  } calc_result_t;

  logic                          clk;
  logic                          rst;
  logic                          req_valid;
  logic                          req_stall;
  logic [2:0]                    mode;
  logic signed [rsc_pkg::DW-1:0] value;
  logic                          rsp_valid;
  logic                          rsp_stall;
  logic [2:0]                    status;
  logic signed [rsc_pkg::DW-1:0] data;
  logic                          is_empty;
  logic [6:0]                    depth;

  logic [31:0]  calc_mem [STACK_DEPTH];
  int           calc_count;
  calc_result_t pending_results[$];
  int           beats_sent;
  int           beats_checked;
  int           mismatches;
  int           cycle_count;
  int           status_seen [5];
  bit           req_gaps_on;
  bit           rsp_stall_on;
  int           hold_req;

  rpn_stack_calculator_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .mode      (mode),
    .value     (value),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .data      (data),
    .is_empty  (is_empty),
    .depth     (depth)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [31:0] trunc_quot(input logic [31:0] lhs, input logic [31:0] rhs);
    logic [31:0] mag_l;
    logic [31:0] mag_r;
    logic [31:0] q;
    mag_l = lhs[31] ? (32'd0 - lhs) : lhs;
    mag_r = rhs[31] ? (32'd0 - rhs) : rhs;
    q     = mag_l / mag_r;
    return (lhs[31] ^ rhs[31]) ? (32'd0 - q) : q;
  endfunction

  // Applies one request to the shadow stack and returns the result it should produce.
  function automatic calc_result_t calc_apply(input logic [2:0] op, input logic [31:0] operand);
    calc_result_t res;
    logic [31:0]  lhs;
    logic [31:0]  rhs;
    res.status = rsc_pkg::ST_OK;
    res.data   = '0;
    unique case (op)
      rsc_pkg::MODE_PUSH: begin
        if (calc_count >= STACK_DEPTH) begin
          res.status = rsc_pkg::ST_FULL;
        end else begin
          calc_mem[calc_count] = operand;
          calc_count++;
        end
      end
      rsc_pkg::MODE_POP: begin
        if (calc_count == 0) begin
          res.status = rsc_pkg::ST_UNDERFLOW;
        end else begin
          calc_count--;
          res.data = calc_mem[calc_count];
        end
      end
      rsc_pkg::MODE_ADD, rsc_pkg::MODE_SUB, rsc_pkg::MODE_MUL, rsc_pkg::MODE_DIV: begin
        if (calc_count == 0) begin
          res.status = rsc_pkg::ST_UNDERFLOW;
        end else if (calc_count == 1) begin
          calc_count = 0;
          res.status = rsc_pkg::ST_INSUFFICIENT;
        end else begin
          rhs        = calc_mem[calc_count - 1];
          lhs        = calc_mem[calc_count - 2];
          calc_count = calc_count - 2;
          unique case (op)
            rsc_pkg::MODE_ADD: res.data = lhs + rhs;
            rsc_pkg::MODE_SUB: res.data = lhs - rhs;
            rsc_pkg::MODE_MUL: res.data = lhs * rhs;
            default: begin
              if (rhs == 32'd0) res.status = rsc_pkg::ST_DIVZERO;
              else res.data = trunc_quot(lhs, rhs);
            end
          endcase
          if (res.status == rsc_pkg::ST_OK) begin
            calc_mem[calc_count] = res.data;
            calc_count++;
          end
        end
      end
      rsc_pkg::MODE_CLEAR: calc_count = 0;
      default: ;
    endcase
    res.empty = (calc_count == 0);
    res.depth = 7'(calc_count);
    return res;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return ($urandom_range(0, 1) != 0) ? 32'd1 : 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4, 5:    return 32'($urandom_range(0, 40)) - 32'd20;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [2:0] op, input logic [31:0] operand);
    int gap;
    @(negedge clk);
    req_valid <= 1'b1;
    mode      <= op;
    value     <= operand;
    do @(posedge clk); while (req_stall);
    pending_results.push_back(calc_apply(op, operand));
    beats_sent++;
    gap = req_gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic release_request();
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  task automatic test_push_pop();
    send_request(rsc_pkg::MODE_PUSH, 32'h7FFF_FFFF);
    send_request(rsc_pkg::MODE_PUSH, 32'h8000_0000);
    send_request(rsc_pkg::MODE_PUSH, 32'h0000_0000);
    send_request(rsc_pkg::MODE_PUSH, 32'hFFFF_FFFF);
    repeat (4) send_request(rsc_pkg::MODE_POP, $urandom);
    send_request(rsc_pkg::MODE_POP, 32'h0);
  endtask

  task automatic test_operators();
    send_request(rsc_pkg::MODE_ADD, 32'h0);
    send_request(rsc_pkg::MODE_PUSH, 32'd5);
    send_request(rsc_pkg::MODE_DIV, 32'h0);
    send_request(rsc_pkg::MODE_PUSH, 32'h7FFF_FFFF);
    send_request(rsc_pkg::MODE_PUSH, 32'd1);
    send_request(rsc_pkg::MODE_ADD, 32'h0);
    send_request(rsc_pkg::MODE_PUSH, 32'd1);
    send_request(rsc_pkg::MODE_SUB, 32'h0);
    send_request(rsc_pkg::MODE_PUSH, 32'hFFFF_FFFE);
    send_request(rsc_pkg::MODE_MUL, 32'h0);
    send_request(rsc_pkg::MODE_POP, 32'h0);
    send_request(rsc_pkg::MODE_PUSH, 32'hFFFF_FFF9);
    send_request(rsc_pkg::MODE_PUSH, 32'd2);
    send_request(rsc_pkg::MODE_DIV, 32'h0);
    send_request(rsc_pkg::MODE_PUSH, 32'h8000_0000);
    send_request(rsc_pkg::MODE_PUSH, 32'hFFFF_FFFF);
    send_request(rsc_pkg::MODE_DIV, 32'h0);
    send_request(rsc_pkg::MODE_PUSH, 32'd0);
    send_request(rsc_pkg::MODE_DIV, 32'h0);
    send_request(MODE_UNUSED, $urandom);
    send_request(rsc_pkg::MODE_CLEAR, 32'h0);
    send_request(rsc_pkg::MODE_POP, 32'h0);
  endtask

  task automatic test_full_stack();
    repeat (STACK_DEPTH) send_request(rsc_pkg::MODE_PUSH, rand_operand());
    send_request(rsc_pkg::MODE_PUSH, rand_operand());
    send_request(rsc_pkg::MODE_POP, 32'h0);
    send_request(rsc_pkg::MODE_CLEAR, 32'h0);
  endtask

  // Push rate drifts every few dozen beats so the stack swings between shallow and full.
  task automatic test_random(input int count);
    int push_pct;
    int sel;
    logic [2:0] op;
    push_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) push_pct = $urandom_range(25, 80);
      if ($urandom_range(0, 99) < push_pct) begin
        op = rsc_pkg::MODE_PUSH;
      end else begin
        sel = $urandom_range(0, 19);
        if (sel < 3) op = rsc_pkg::MODE_POP;
        else if (sel < 7) op = rsc_pkg::MODE_ADD;
        else if (sel < 11) op = rsc_pkg::MODE_SUB;
        else if (sel < 15) op = rsc_pkg::MODE_MUL;
        else if (sel < 18) op = rsc_pkg::MODE_DIV;
        else if (sel == 18) op = rsc_pkg::MODE_CLEAR;
        else op = MODE_UNUSED;
      end
      send_request(op, rand_operand());
    end
  endtask

  task automatic test_backpressure();
    bit saved_gaps;
    saved_gaps  = req_gaps_on;
    req_gaps_on = 1'b0;
    hold_req    = HOLD_CYCLES;
    test_random(20);
    req_gaps_on = saved_gaps;
  endtask

  initial begin : rsp_pacing
    int stall_left;
    int hold_left;
    rsp_stall  = 1'b0;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
        if (rsp_stall_on && $urandom_range(0, 2) == 0) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin : result_check
    calc_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("cycle %0d: result beat with nothing outstanding (status %0d data %h)",
                   cycle_count, status, data);
      end else begin
        want = pending_results.pop_front();
        beats_checked++;
        if (status < 5) status_seen[status]++;
        if (status !== want.status || data !== want.data ||
            is_empty !== want.empty || depth !== want.depth) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display({"cycle %0d: mismatch exp/act status %0d/%0d data %h/%h ",
                      "empty %0b/%0b depth %0d/%0d"}, cycle_count,
                     want.status, status, want.data, data,
                     want.empty, is_empty, want.depth, depth);
        end
      end
    end
  end

  initial begin
    rst          = 1'b1;
    req_valid    = 1'b0;
    mode         = rsc_pkg::MODE_PUSH;
    value        = '0;
    calc_count   = 0;
    req_gaps_on  = 1'b1;
    rsp_stall_on = 1'b1;
    hold_req     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_push_pop();
    test_operators();
    test_full_stack();
    test_random(100);
    test_backpressure();
    req_gaps_on  = 1'b0;
    rsp_stall_on = 1'b0;
    test_random(100);
    req_gaps_on  = 1'b1;
    rsp_stall_on = 1'b1;
    test_random(100);
    release_request();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d result beats checked, incl. a %0d-cycle output hold-off",
             beats_sent, beats_checked, HOLD_CYCLES);
    $display("status mix ok/underflow/few/divzero/full: %0d/%0d/%0d/%0d/%0d; %0d mismatches",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
